// ===== hdl/ovl_pkg.sv =====
`timescale 1ns / 1ps

package ovl_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int OP_W     = 3;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 5;

	localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
	localparam logic [OP_W-1:0] OP_FRONT   = 3'd1;
	localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
	localparam logic [OP_W-1:0] OP_SEARCH  = 3'd3;
	localparam logic [OP_W-1:0] OP_DISPLAY = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISS  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

endpackage

// ===== hdl/ordered_value_list_unit.sv =====
`timescale 1ns / 1ps

// Bounded ordered list of signed 32-bit values held in a single memory with one write
// and one registered read per cycle. A transaction is taken when start is high and busy
// is low; its results appear one per cycle on result_valid and must be taken as shown,
// since the receiver cannot stall. Append, unused codes, inserts into a full list and
// operations on an empty list keep busy low, and the result shows in the next cycle.
// Insert at the front moves every entry up one place, starting at the tail, and then
// writes the new value at the head. Search and delete scan from the head through the
// registered read, one entry a cycle until a match; a delete then moves the tail down.
// Display gives one entry a cycle through the registered read. The final result shows
// in the first cycle after busy falls, when the next transaction can already be taken.
// The memory needs no clearing after reset: only entries below the count are ever read.
module ordered_value_list_unit
	import ovl_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [OP_W-1:0]            operation,
	input  logic signed [VAL_W-1:0]    item_value,
	output logic                       result_valid,
	output logic                       found,
	output logic signed [VAL_W-1:0]    entry_value,
	output logic [STATUS_W-1:0]        status,
	output logic                       last,
	output logic [LEN_W-1:0]           list_length
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		IDLE,
		FRONT,
		FRONT_HEAD,
		SCAN,
		DEL_SHIFT,
		DISPLAY
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic [OP_W-1:0]         op_q;
	logic signed [VAL_W-1:0] key_q;
	logic [IW-1:0]           rp_q;
	logic                    issuing_q;

	logic signed [VAL_W-1:0] mem [CAPACITY];
	logic                    rd_vld_s1;
	logic [IW-1:0]           rd_idx_s1;
	logic signed [VAL_W-1:0] rdata_s1;

	logic                    rd_en;
	logic                    wr_en;
	logic [IW-1:0]           wr_addr;
	logic signed [VAL_W-1:0] wr_data;
	logic [CW-1:0]           cnt_p1;
	logic [CW-1:0]           cnt_m1;
	logic [IW-1:0]           last_idx;
	logic                    full;
	logic                    rd_last_s1;
	logic                    hit_s1;

	assign busy     = (state_q != IDLE);
	assign cnt_p1   = count_q + CW'(1);
	assign cnt_m1   = count_q - CW'(1);
	assign last_idx = cnt_m1[IW-1:0];
	assign full     = (count_q == CW'(CAPACITY));
	assign rd_last_s1 = rd_vld_s1 && (rd_idx_s1 == last_idx);
	assign hit_s1     = rd_vld_s1 && (rdata_s1 == key_q);

	always_comb begin
		rd_en = 1'b0;
		case (state_q)
			FRONT, DEL_SHIFT, DISPLAY: rd_en = issuing_q;
			SCAN:                      rd_en = issuing_q && !hit_s1;
			default:                   rd_en = 1'b0;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IW-1:0];
		wr_data = item_value;
		case (state_q)
			IDLE: begin
				// An empty list takes a front insert at the same place as an append.
				wr_en = start && !full && ((operation == OP_APPEND) ||
					((operation == OP_FRONT) && (count_q == '0)));
			end
			FRONT: begin
				wr_en   = rd_vld_s1;
				wr_addr = rd_idx_s1 + IW'(1);
				wr_data = rdata_s1;
			end
			FRONT_HEAD: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = key_q;
			end
			DEL_SHIFT: begin
				wr_en   = rd_vld_s1;
				wr_addr = rd_idx_s1 - IW'(1);
				wr_data = rdata_s1;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rp_q];
		end
		rd_idx_s1 <= rp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			count_q      <= '0;
			issuing_q    <= 1'b0;
			result_valid <= 1'b0;
			op_q         <= OP_APPEND;
			key_q        <= '0;
			rp_q         <= '0;
			found        <= 1'b0;
			entry_value  <= '0;
			status       <= ST_OK;
			last         <= 1'b0;
			list_length  <= '0;
		end else begin
			result_valid <= 1'b0;
			found        <= 1'b0;
			entry_value  <= '0;
			status       <= ST_OK;
			last         <= 1'b1;
			list_length  <= LEN_W'(count_q);
			unique case (state_q)
				IDLE: begin
					if (start) begin
						op_q  <= operation;
						key_q <= item_value;
						case (operation)
							OP_APPEND, OP_FRONT: begin
								if (full) begin
									result_valid <= 1'b1;
									status       <= ST_FULL;
								end else if ((operation == OP_APPEND) || (count_q == '0)) begin
									count_q      <= cnt_p1;
									result_valid <= 1'b1;
									list_length  <= LEN_W'(cnt_p1);
								end else begin
									state_q   <= FRONT;
									rp_q      <= last_idx;
									issuing_q <= 1'b1;
								end
							end
							OP_DELETE, OP_SEARCH, OP_DISPLAY: begin
								if (count_q == '0) begin
									result_valid <= 1'b1;
									status <= (operation == OP_DISPLAY) ? ST_EMPTY : ST_MISS;
								end else begin
									state_q   <= (operation == OP_DISPLAY) ? DISPLAY : SCAN;
									rp_q      <= '0;
									issuing_q <= 1'b1;
								end
							end
							default: begin
								result_valid <= 1'b1;
							end
						endcase
					end
				end
				FRONT: begin
					// Walks from the tail down so that no entry is overwritten before it moves.
					if (rd_en) begin
						rp_q      <= rp_q - IW'(1);
						issuing_q <= (rp_q != '0);
					end
					if (rd_vld_s1 && (rd_idx_s1 == '0)) begin
						state_q <= FRONT_HEAD;
					end
				end
				FRONT_HEAD: begin
					count_q      <= cnt_p1;
					result_valid <= 1'b1;
					list_length  <= LEN_W'(cnt_p1);
					state_q      <= IDLE;
				end
				SCAN: begin
					if (hit_s1) begin
						if ((op_q == OP_SEARCH) || rd_last_s1) begin
							result_valid <= 1'b1;
							found        <= 1'b1;
							state_q      <= IDLE;
							if (op_q != OP_SEARCH) begin
								count_q     <= cnt_m1;
								list_length <= LEN_W'(cnt_m1);
							end
						end else begin
							// Restart reads just past the match to close the gap.
							state_q   <= DEL_SHIFT;
							rp_q      <= rd_idx_s1 + IW'(1);
							issuing_q <= 1'b1;
						end
					end else begin
						if (rd_en) begin
							rp_q      <= rp_q + IW'(1);
							issuing_q <= (rp_q != last_idx);
						end
						if (rd_last_s1) begin
							result_valid <= 1'b1;
							status       <= ST_MISS;
							state_q      <= IDLE;
						end
					end
				end
				DEL_SHIFT: begin
					if (rd_en) begin
						rp_q      <= rp_q + IW'(1);
						issuing_q <= (rp_q != last_idx);
					end
					if (rd_last_s1) begin
						count_q      <= cnt_m1;
						result_valid <= 1'b1;
						found        <= 1'b1;
						list_length  <= LEN_W'(cnt_m1);
						state_q      <= IDLE;
					end
				end
				DISPLAY: begin
					if (rd_en) begin
						rp_q      <= rp_q + IW'(1);
						issuing_q <= (rp_q != last_idx);
					end
					if (rd_vld_s1) begin
						result_valid <= 1'b1;
						entry_value  <= rdata_s1;
						last         <= rd_last_s1;
						if (rd_last_s1) begin
							state_q <= IDLE;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/ovl_checker.sv =====
`timescale 1ns / 1ps

module ovl_checker
	import ovl_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic [OP_W-1:0]         operation,
	input logic signed [VAL_W-1:0] item_value,
	input logic                    result_valid,
	input logic                    found,
	input logic signed [VAL_W-1:0] entry_value,
	input logic [STATUS_W-1:0]     status,
	input logic                    last,
	input logic [LEN_W-1:0]        list_length
);

	// Every accepted transaction either shows a result next cycle or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || result_valid)
		else $error("accepted transaction made no progress");

	// A display run continues without gaps until its last entry.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy ##1 result_valid)
		else $error("display run broken before its last entry");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && found |-> status == ST_OK && last && entry_value == '0)
		else $error("found result with bad fields");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_EMPTY |-> last && !found && list_length == '0 &&
			entry_value == '0)
		else $error("empty display result with bad fields");

endmodule

bind ordered_value_list_unit ovl_checker u_ovl_checker (.*);
